// ===== rtl/sal_pkg.sv =====
// Shared types and codes for the sorted linked list core.
`timescale 1ns / 1ps

package sal_pkg;

    // Request opcodes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_COUNT  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Which slot index the result reports
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_NEW,
        SEL_HIT
    } slot_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;        // capture request beat
        logic      clear;       // rebuild empty list
        logic      walk_start;  // start walk at list head
        logic      walk_step;   // evaluate one slot of the walk
        logic      pop_read;    // read link of free head
        logic      ins_link;    // write key and link of new slot
        logic      ins_prev;    // link predecessor to new slot
        logic      del_unlink;  // bypass the hit slot
        logic      del_free;    // push hit slot onto free chain
        logic      result;      // load output register
        logic [1:0] res_status;
        slot_sel_t res_sel;
    } sal_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       head_end;   // list empty
        logic       free_empty; // pool full
        logic       walk_stop;  // walk ends this cycle
        logic       found;      // walk stopped on a matching key
        logic       out_busy;   // output register cannot take a beat
    } sal_stat_t;

endpackage

// ===== rtl/sal_ctrl.sv =====
// Controller state machine for the sorted linked list core.
`timescale 1ns / 1ps

module sal_ctrl
    import sal_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sal_stat_t stat,
    output sal_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_DECIDE,
        S_POP,
        S_INS_LINK,
        S_INS_PREV,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_DONE
    } state_t;

    state_t    state_reg, state_next;
    logic [1:0] res_status_reg, res_status_next;
    slot_sel_t res_sel_reg, res_sel_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_sel_next    = res_sel_reg;
        cmd             = '0;
        cmd.res_status  = res_status_reg;
        cmd.res_sel     = res_sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_status_next = ST_OK;
                res_sel_next    = SEL_NONE;
                case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.free_empty)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = stat.head_end ? S_DECIDE : S_WALK;
                        end
                    end
                    OP_DELETE, OP_SEARCH:
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = stat.head_end ? S_DECIDE : S_WALK;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_stop)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.found)
                        begin
                            res_status_next = ST_MISS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (stat.found)
                        begin
                            state_next = S_DEL_UNLINK;
                        end
                        else
                        begin
                            res_status_next = ST_MISS;
                            state_next      = S_DONE;
                        end
                    end
                    default:
                    begin
                        if (stat.found)
                        begin
                            res_sel_next = SEL_HIT;
                        end
                        else
                        begin
                            res_status_next = ST_MISS;
                        end
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP:
            begin
                cmd.pop_read = 1'b1;
                state_next   = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                cmd.ins_link = 1'b1;
                state_next   = S_INS_PREV;
            end
            S_INS_PREV:
            begin
                cmd.ins_prev = 1'b1;
                res_sel_next = SEL_NEW;
                state_next   = S_DONE;
            end
            S_DEL_UNLINK:
            begin
                cmd.del_unlink = 1'b1;
                state_next     = S_DEL_FREE;
            end
            S_DEL_FREE:
            begin
                cmd.del_free = 1'b1;
                res_sel_next = SEL_HIT;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
            res_sel_reg    <= SEL_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_sel_reg    <= res_sel_next;
        end
    end

endmodule

// ===== rtl/sal_dp.sv =====
// Datapath for the sorted linked list core: slot memories, chain heads, walk and output register.
`timescale 1ns / 1ps

module sal_dp
    import sal_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [5:0]         slot,
    output logic [6:0]         held,
    input  sal_cmd_t           cmd,
    output sal_stat_t          stat
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] END_MARK  = LW'(CAPACITY);
    localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

    // Slot memories
    logic signed [31:0] key_mem  [CAPACITY];
    logic [LW-1:0]      link_mem [CAPACITY];

    // Read port and its registered data
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic signed [31:0] key_rd_reg;
    logic [LW-1:0]      link_rd_reg;
    logic [IW-1:0]      rd_idx_reg;

    // Link write port
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [LW-1:0] wr_data;
    logic          key_wr_en;

    // Request, chain and walk registers
    logic [2:0]         op_reg;
    logic signed [31:0] key_reg;
    logic [LW-1:0]      head_reg, head_next;
    logic [LW-1:0]      free_reg, free_next;
    logic [LW-1:0]      count_reg, count_next;
    logic [LW-1:0]      fill_reg, fill_next;
    logic [LW-1:0]      prev_reg, prev_next;
    logic [LW-1:0]      prev_link_reg, prev_link_next;
    logic [IW-1:0]      hit_reg, hit_next;
    logic [LW-1:0]      hit_link_reg, hit_link_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      steps_reg, steps_next;
    logic [IW-1:0]      new_reg, new_next;

    // Output register
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [5:0]         slot_reg;
    logic [6:0]         held_reg;
    logic [IW-1:0]      res_idx;
    logic [IW+5:0]      slot_wide;
    logic [LW+6:0]      held_wide;

    // Walk helpers
    logic [LW-1:0] rd_idx_ext;
    logic [LW-1:0] link_adj;
    logic          key_less;
    logic          next_ok;
    logic          at_bound;
    logic          prev_ok;

    // Slots at or above the fill mark are untouched since the last rebuild
    // and still link to their successor.
    assign rd_idx_ext = LW'(rd_idx_reg);
    assign link_adj   = (rd_idx_ext >= fill_reg) ? (rd_idx_ext + LW'(1)) : link_rd_reg;
    assign key_less   = (key_rd_reg < key_reg);
    assign next_ok    = (link_adj < END_MARK);
    assign at_bound   = (steps_reg == LAST_STEP);
    assign prev_ok    = (prev_reg < END_MARK);

    // Status towards the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.head_end   = !(head_reg < END_MARK);
        stat.free_empty = !(free_reg < END_MARK);
        stat.walk_stop  = key_less ? (at_bound || !next_ok) : 1'b1;
        stat.found      = found_reg;
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    // Memory ports and next register values
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = head_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = new_reg;
        wr_data        = head_reg;
        key_wr_en      = 1'b0;
        head_next      = head_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        prev_next      = prev_reg;
        prev_link_next = prev_link_reg;
        hit_next       = hit_reg;
        hit_link_next  = hit_link_reg;
        found_next     = found_reg;
        steps_next     = steps_reg;
        new_next       = new_reg;

        // rebuild the empty list
        if (cmd.clear)
        begin
            head_next  = END_MARK;
            free_next  = '0;
            count_next = '0;
            fill_next  = '0;
        end

        // walk from the head
        if (cmd.walk_start)
        begin
            prev_next  = END_MARK;
            steps_next = '0;
            found_next = 1'b0;
            if (head_reg < END_MARK)
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg[IW-1:0];
            end
        end

        // one slot of the walk
        if (cmd.walk_step)
        begin
            if (key_less)
            begin
                prev_next      = rd_idx_ext;
                prev_link_next = link_adj;
                steps_next     = steps_reg + IW'(1);
                if (!at_bound && next_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = link_adj[IW-1:0];
                end
            end
            else
            begin
                found_next    = (key_rd_reg == key_reg);
                hit_next      = rd_idx_reg;
                hit_link_next = link_adj;
            end
        end

        // fetch the link of the slot taken from the free chain
        if (cmd.pop_read)
        begin
            rd_en    = 1'b1;
            rd_addr  = free_reg[IW-1:0];
            new_next = free_reg[IW-1:0];
        end

        // fill the new slot and splice it in behind the predecessor, or at the head
        if (cmd.ins_link)
        begin
            free_next = link_adj;
            key_wr_en = 1'b1;
            wr_en     = 1'b1;
            wr_addr   = new_reg;
            if (prev_ok)
            begin
                wr_data = prev_link_reg;
            end
            else
            begin
                wr_data   = head_reg;
                head_next = LW'(new_reg);
            end
            if (LW'(new_reg) >= fill_reg)
            begin
                fill_next = LW'(new_reg) + LW'(1);
            end
        end

        if (cmd.ins_prev)
        begin
            if (prev_ok)
            begin
                wr_en   = 1'b1;
                wr_addr = prev_reg[IW-1:0];
                wr_data = LW'(new_reg);
            end
            if (count_reg < END_MARK)
            begin
                count_next = count_reg + LW'(1);
            end
        end

        // unlink the hit slot
        if (cmd.del_unlink)
        begin
            if (prev_ok)
            begin
                wr_en   = 1'b1;
                wr_addr = prev_reg[IW-1:0];
                wr_data = hit_link_reg;
            end
            else
            begin
                head_next = hit_link_reg;
            end
        end

        // return the hit slot to the free chain
        if (cmd.del_free)
        begin
            wr_en     = 1'b1;
            wr_addr   = hit_reg;
            wr_data   = free_reg;
            free_next = LW'(hit_reg);
            if (count_reg != '0)
            begin
                count_next = count_reg - LW'(1);
            end
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (key_wr_en)
        begin
            key_mem[new_reg] <= key_reg;
        end
        if (rd_en)
        begin
            key_rd_reg  <= key_mem[rd_addr];
            link_rd_reg <= link_mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= END_MARK;
            free_reg      <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            found_reg <= found_next;
            if (cmd.result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        prev_reg      <= prev_next;
        prev_link_reg <= prev_link_next;
        hit_reg       <= hit_next;
        hit_link_reg  <= hit_link_next;
        steps_reg     <= steps_next;
        new_reg       <= new_next;
        if (cmd.result)
        begin
            status_reg <= cmd.res_status;
            slot_reg   <= slot_wide[5:0];
            held_reg   <= held_wide[6:0];
        end
    end

    // Result fields, slot index and count masked to port width
    always_comb
    begin
        case (cmd.res_sel)
            SEL_NEW: res_idx = new_reg;
            SEL_HIT: res_idx = hit_reg;
            default: res_idx = '0;
        endcase
    end

    assign slot_wide = (IW + 6)'(res_idx);
    assign held_wide = (LW + 7)'(count_reg);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign held      = held_reg;

endmodule

// ===== rtl/sorted_array_linked_list_core.sv =====
// Top level of the sorted linked list core: controller plus datapath.
//
// Keeps signed 32-bit keys in a pool of CAPACITY slots as an ascending
// linked list, with a free chain of unused slots. Requests come in on the
// in_valid / in_ready channel (opcode, key); each request yields exactly
// one result beat on out_valid / out_ready (status, slot, held).
// Opcodes: insert, delete, search, count, clear; unused codes act as count.
// One request is worked on at a time; the next is taken in the cycle after
// the previous result is loaded. Each request is decoded first. Insert,
// delete and search then walk the ordered chain from the head, one slot
// per cycle, bounded by the single read port of the slot memory and
// visiting at most CAPACITY slots. A successful insert then takes the free
// head, fills it and links its predecessor to it; a successful delete
// unlinks the hit slot and pushes it onto the free chain. Count, clear and
// an insert into a full pool skip the walk.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and worked on, and only its result waits.
// Reset gives an empty list and an all-free pool; no clearing
// pass over the memories is needed.
`timescale 1ns / 1ps

module sorted_array_linked_list_core
    import sal_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [5:0]         slot,
    output logic [6:0]         held
);

    sal_cmd_t  cmd;
    sal_stat_t stat;

    sal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .opcode    (opcode),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .slot      (slot),
        .held      (held),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
